// File: sv/prefilled_moving_average_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the prefilled moving average core
// Clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef PREFILLED_MOVING_AVERAGE_CORE_ASSERT_SVH
`define PREFILLED_MOVING_AVERAGE_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PMA_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("moving average core: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PMA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("moving average core: next-cycle check failed");

`endif

// File: sv/pma_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pma_pkg
// Shared constants and types of the prefilled moving average core.
// ----------------------------------------------------------------------------
package pma_pkg;

	localparam int WINDOW_DEPTH      = 64;
	localparam int SAMPLES_PER_ITEM  = 8;
	localparam int NUM_SAMPLE_FIELDS = 8;
	localparam int SAMPLE_W          = 10;
	localparam int ENTRY_SHIFT       = 3;
	localparam int SUM_W             = SAMPLE_W + $clog2(NUM_SAMPLE_FIELDS);
	localparam int ENTRY_W           = SUM_W + ENTRY_SHIFT;
	localparam int DEPTH_W           = $clog2(WINDOW_DEPTH);
	localparam int TOTAL_W           = ENTRY_W + DEPTH_W;
	localparam int AVG_SHIFT         = DEPTH_W + ENTRY_SHIFT;
	localparam int AVERAGE_W         = 13;
	localparam int IN_TDATA_W        = ((NUM_SAMPLE_FIELDS * SAMPLE_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W       = ((AVERAGE_W + 7) / 8) * 8;

	typedef logic [ENTRY_W-1:0] entry_t;
	typedef logic [TOTAL_W-1:0] total_t;

	// Per-cycle commands shared by every cell of the window chain.
	typedef struct packed {
		logic shift;
		logic fill;
	} cell_ctrl_t;

endpackage

// File: sv/prefilled_moving_average_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prefilled_moving_average_core
// Boxcar average over the last 64 scaled sample sums, prefilled on first use.
// ----------------------------------------------------------------------------
// Usage:
// Each input word on s_axis carries eight 10-bit samples. Their sum times 8
// is one window entry; each input word gives one output word on m_axis with
// the sum of the last 64 entries divided by 512, truncated.
// The window is a chain of 64 cells that shifts by one on every processed
// word; a running total drops the entry leaving the chain's end and adds
// the new one, so no re-summing is needed.
// Pipeline: an accepted word's entry is registered in the adder stage, then
// its average in the output register. Throughput: one word per cycle unless
// m_axis stalls, set by the chain stage's single total update per cycle.
// Reset: the window is marked empty; the first word after reset fills every
// cell with its entry, so the first average equals that entry divided by 8.
// Stall: the result stays in the output register while m_axis_tready is low;
// one more word can still be taken into the adder stage, then s_axis_tready
// drops until the output is taken.
// ----------------------------------------------------------------------------
module prefilled_moving_average_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// sample_0 [9:0], sample_1 [19:10], ... sample_7 [79:70]
	input  logic [pma_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// average [12:0], zeros above
	output logic [pma_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import pma_pkg::*;

	logic                 valid_s1;
	entry_t               entry_s1;
	logic                 out_free;
	logic                 advance;
	logic                 in_accept;
	logic                 empty_q;
	total_t               total_q;
	total_t               next_total;
	logic [AVERAGE_W-1:0] average_q;
	logic                 out_valid_q;
	cell_ctrl_t           cell_ctrl;
	entry_t               cells [WINDOW_DEPTH];

	assign out_free      = !out_valid_q || m_axis_tready;
	assign advance       = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	pma_entry u_entry (
		.clk      (clk),
		.load     (in_accept),
		.tdata    (s_axis_tdata),
		.entry_s1 (entry_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	assign cell_ctrl.shift = advance;
	assign cell_ctrl.fill  = empty_q;

	for (genvar g = 0; g < WINDOW_DEPTH; g++) begin : g_cell
		pma_cell u_cell (
			.clk        (clk),
			.ctrl       (cell_ctrl),
			.fill_value (entry_s1),
			.shift_in   ((g == 0) ? entry_s1 : cells[(g == 0) ? 0 : g - 1]),
			.value_q    (cells[g])
		);
	end

	// The last cell holds the oldest entry, the one the new entry replaces.
	always_comb begin
		if (empty_q) begin
			next_total = total_t'(entry_s1) << DEPTH_W;
		end else begin
			next_total = total_q - total_t'(cells[WINDOW_DEPTH-1]) + total_t'(entry_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			empty_q     <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				empty_q <= 1'b0;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			total_q   <= next_total;
			average_q <= next_total[AVG_SHIFT +: AVERAGE_W];
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_TDATA_W'(average_q);

`include "prefilled_moving_average_core_assert.svh"

	`PMA_ASSERT_NEXT(a_result_follows, advance, m_axis_tvalid)
	`PMA_ASSERT_NEXT(a_prefill_once, advance, !empty_q)
	`PMA_ASSERT_SAME(a_avg_matches_total, m_axis_tvalid,
		average_q == total_q[AVG_SHIFT +: AVERAGE_W])
	`PMA_ASSERT_SAME(a_no_overrun, in_accept && valid_s1, advance)

endmodule

// File: sv/pma_entry.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pma_entry
// First pipeline stage: adds the samples of one word and scales the sum by 8.
// ----------------------------------------------------------------------------
module pma_entry (
	input  logic                           clk,
	input  logic                           load,
	input  logic [pma_pkg::IN_TDATA_W-1:0] tdata,
	output pma_pkg::entry_t                entry_s1
);
	import pma_pkg::*;

	logic [SUM_W-1:0] sum;

	always_comb begin
		sum = '0;
		for (int k = 0; k < SAMPLES_PER_ITEM; k++) begin
			sum = sum + SUM_W'(tdata[k*SAMPLE_W +: SAMPLE_W]);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			entry_s1 <= {sum, ENTRY_SHIFT'(0)};
		end
	end

endmodule

// File: sv/pma_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pma_cell
// One window entry; takes its left neighbor's entry on a shift, or the new
// entry when the whole window is prefilled.
// ----------------------------------------------------------------------------
module pma_cell (
	input  logic                clk,
	input  pma_pkg::cell_ctrl_t ctrl,
	input  pma_pkg::entry_t     fill_value,
	input  pma_pkg::entry_t     shift_in,
	output pma_pkg::entry_t     value_q
);
	import pma_pkg::*;

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			value_q <= ctrl.fill ? fill_value : shift_in;
		end
	end

endmodule

// File: tb/prefilled_moving_average_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prefilled_moving_average_checker
// Watches both streams of the moving average core, predicts every average
// from the accepted input words and compares it with the output words.
// ----------------------------------------------------------------------------
module prefilled_moving_average_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	input  logic                            s_axis_tready,
	// sample_0 [9:0], sample_1 [19:10], ... sample_7 [79:70]
	input  logic [pma_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	input  logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// average [12:0], zeros above
	input  logic [pma_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	output int                              failures,
	output int                              pending
);
	import pma_pkg::*;

	logic [AVERAGE_W-1:0] average_queue [$];
	entry_t               window_entries [WINDOW_DEPTH];
	logic [DEPTH_W-1:0]   write_slot;
	logic                 window_unfilled;
	total_t               running_total;

	always @(posedge clk or negedge arst_n) begin : track
		entry_t               entry;
		logic [AVERAGE_W-1:0] actual;
		logic [AVERAGE_W-1:0] expected;
		int                   k;
		if (!arst_n) begin
			average_queue.delete();
			write_slot      = '0;
			window_unfilled = 1'b1;
			running_total   = '0;
			failures        = 0;
			pending         = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				actual = m_axis_tdata[AVERAGE_W-1:0];
				if (average_queue.size() == 0) begin
					failures++;
					if (failures <= 10)
						$display("%0t: average word %0d arrived with nothing pending",
							$time, actual);
				end else begin
					expected = average_queue.pop_front();
					if (actual !== expected) begin
						failures++;
						if (failures <= 10)
							$display("%0t: average mismatch, expected %0d, got %0d",
								$time, expected, actual);
					end
				end
			end

			if (s_axis_tvalid && s_axis_tready) begin
				entry = '0;
				for (k = 0; k < SAMPLES_PER_ITEM; k++)
					entry += entry_t'(s_axis_tdata[k*SAMPLE_W +: SAMPLE_W]) << ENTRY_SHIFT;
				// The first word after reset stands in for the whole window.
				if (window_unfilled) begin
					for (k = 0; k < WINDOW_DEPTH; k++)
						window_entries[k] = entry;
					running_total   = total_t'(entry) << DEPTH_W;
					window_unfilled = 1'b0;
				end else begin
					running_total = running_total - total_t'(window_entries[write_slot])
						+ total_t'(entry);
					window_entries[write_slot] = entry;
				end
				average_queue.push_back(AVERAGE_W'(running_total >> AVG_SHIFT));
				write_slot = (write_slot == DEPTH_W'(WINDOW_DEPTH - 1)) ? '0
					: write_slot + DEPTH_W'(1);
			end
			pending = average_queue.size();
		end
	end

endmodule

// File: tb/tb_prefilled_moving_average_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_prefilled_moving_average_core
// Drives sample words into the moving average core under varying back
// pressure and reports the verdict of the checker beside it.
// ----------------------------------------------------------------------------
module tb_prefilled_moving_average_core;

	import pma_pkg::*;

	localparam int CYCLE_LIMIT      = 400000;
	localparam int RANDOM_PER_PHASE = 630;
	localparam int SAMPLE_MAX       = (1 << SAMPLE_W) - 1;

	typedef logic [SAMPLE_W-1:0] sample_set_t [NUM_SAMPLE_FIELDS];

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	int failures;
	int pending;
	int send_idle_pct = 17;
	int recv_idle_pct = 85;
	int cycle_count   = 0;

	always #5 clk = ~clk;

	prefilled_moving_average_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	prefilled_moving_average_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.failures      (failures),
		.pending       (pending)
	);

	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[prefilled_moving_average_core] ERROR");
			$finish;
		end
	end

	// Offers one word, with random idle cycles ahead of it, and holds it
	// until the core takes it.
	task automatic send_samples(input sample_set_t set);
		logic [IN_TDATA_W-1:0] word;
		int                    k;
		word = '0;
		for (k = 0; k < NUM_SAMPLE_FIELDS; k++)
			word[k*SAMPLE_W +: SAMPLE_W] = set[k];
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= word;
		do
			@(posedge clk);
		while (!s_axis_tready);
	endtask

	initial begin : stimulus
		sample_set_t set;
		int          phase;
		int          sent;
		int          run_length;
		int          level;
		int          k;
		int          n;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 17;
					recv_idle_pct = 85;
				end
				1: begin
					send_idle_pct = 85;
					recv_idle_pct = 17;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase

			if (phase == 0) begin
				// Full scale first, so the prefilled window starts at the top.
				for (k = 0; k < NUM_SAMPLE_FIELDS; k++) set[k] = SAMPLE_W'(SAMPLE_MAX);
				send_samples(set);
				for (k = 0; k < NUM_SAMPLE_FIELDS; k++) set[k] = '0;
				send_samples(set);
				for (n = 0; n < NUM_SAMPLE_FIELDS; n++) begin
					for (k = 0; k < NUM_SAMPLE_FIELDS; k++)
						set[k] = (k == n) ? SAMPLE_W'(SAMPLE_MAX) : '0;
					send_samples(set);
				end
				for (k = 0; k < NUM_SAMPLE_FIELDS; k++) set[k] = 10'h2AA;
				send_samples(set);
				for (k = 0; k < NUM_SAMPLE_FIELDS; k++) set[k] = 10'h155;
				send_samples(set);
				for (k = 0; k < NUM_SAMPLE_FIELDS; k++) set[k] = SAMPLE_W'(1 << k);
				send_samples(set);
				for (k = 0; k < NUM_SAMPLE_FIELDS; k++)
					set[k] = SAMPLE_W'(1 << (SAMPLE_W - 1 - k));
				send_samples(set);
				for (k = 0; k < NUM_SAMPLE_FIELDS; k++) set[k] = SAMPLE_W'(k * 146);
				send_samples(set);
			end

			sent = 0;
			while (sent < RANDOM_PER_PHASE) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5: begin
						for (k = 0; k < NUM_SAMPLE_FIELDS; k++)
							set[k] = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
						send_samples(set);
						sent++;
					end
					6, 7: begin
						for (k = 0; k < NUM_SAMPLE_FIELDS; k++)
							set[k] = $urandom_range(0, 1) ? SAMPLE_W'(SAMPLE_MAX) : '0;
						send_samples(set);
						sent++;
					end
					default: begin
						// A steady level run of 32 to 96 words; runs of 64 or more flush the whole window.
						case ($urandom_range(0, 2))
							0:       level = 0;
							1:       level = SAMPLE_MAX;
							default: level = $urandom_range(0, SAMPLE_MAX);
						endcase
						run_length = $urandom_range(WINDOW_DEPTH / 2, WINDOW_DEPTH + 32);
						for (n = 0; n < run_length; n++) begin
							for (k = 0; k < NUM_SAMPLE_FIELDS; k++) set[k] = SAMPLE_W'(level);
							send_samples(set);
						end
						sent += run_length;
					end
				endcase
			end
		end

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);

		if (failures == 0 && pending == 0)
			$display("[prefilled_moving_average_core] OK");
		else
			$display("[prefilled_moving_average_core] ERROR");
		$finish;
	end

endmodule

// File: sim.f
+incdir+sv
sv/pma_pkg.sv
sv/pma_entry.sv
sv/pma_cell.sv
sv/prefilled_moving_average_core.sv
tb/prefilled_moving_average_checker.sv
tb/tb_prefilled_moving_average_core.sv
